FILE: src/srwm_pkg.sv
// Package: shared constants, types and codes for the sensor rate window monitor
`default_nettype none
package srwm_pkg;

    // Window length in ticks
    localparam int unsigned WINDOW_LEN = 100;

    // Width of the fill counter and of the true window sum
    localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
    // Width of the reported window sum (at least the 7 bits of the rate field)
    localparam int unsigned WSUM_W = (FILL_W > 7) ? FILL_W : 7;
    // Width of the scaled comparisons (100 * sum fits in 7 extra bits)
    localparam int unsigned CMP_W  = WSUM_W + 7;

    // Configuration register widths
    localparam int unsigned EXP_W  = 7;
    localparam int unsigned WAIT_W = 16;
    localparam int unsigned RPT_W  = 4;
    localparam int unsigned CFG_W  = 16;

    // Configuration reset values
    localparam logic [EXP_W-1:0]  EXP_RST  = EXP_W'(100);
    localparam logic [WAIT_W-1:0] WAIT_RST = WAIT_W'(1000);
    localparam logic [RPT_W-1:0]  RPT_RST  = RPT_W'(10);
    localparam logic [RPT_W-1:0]  RPT_MAX  = RPT_W'(15);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_EXPECTED = 2'd0,
        CFG_STARTUP  = 2'd1,
        CFG_REPEAT   = 2'd2
    } t_cfg_idx;

    // Alarm severity codes
    typedef enum logic [1:0] {
        LVL_INFO  = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_ERROR = 2'd2
    } t_level;

    // Window status after the current tick's update
    typedef struct packed {
        logic              full;
        logic [WSUM_W-1:0] sum;
    } t_win_stat;

    // One result item
    typedef struct packed {
        logic       alarm;
        t_level     level;
        logic [6:0] rate;
        logic       checking;
    } t_result;

endpackage
`default_nettype wire

FILE: src/srwm_cell.sv
// One history cell: holds one heard bit and hands it to the next cell
`default_nettype none
module srwm_cell (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_shift,
    input  wire logic i_bit,
    output logic      o_bit
);

    logic r_bit;

    // Take the neighbour's bit on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_bit;
        end
    end

    assign o_bit = r_bit;

endmodule
`default_nettype wire

FILE: src/srwm_window.sv
// Sliding window: chain of history cells, fill counter and running sums
`default_nettype none
module srwm_window (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_shift,
    input  wire logic                i_heard,
    output srwm_pkg::t_win_stat      o_stat
);
    import srwm_pkg::*;

    logic [WINDOW_LEN:0] chain;
    logic [FILL_W-1:0]   r_fill,       n_fill;
    logic [FILL_W-1:0]   r_hist_sum,   n_hist_sum;
    logic [WSUM_W-1:0]   r_window_sum, n_window_sum;
    logic                full_before;

    assign chain[0] = i_heard;

    // Row of cells; the last cell holds the oldest bit
    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
        srwm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_bit   (chain[k]),
            .o_bit   (chain[k+1])
        );
    end

    // Track the sum of all cells, fill level and the reported sum
    always_comb begin
        full_before  = (r_fill == FILL_W'(WINDOW_LEN));
        n_hist_sum   = r_hist_sum + FILL_W'(i_heard) - FILL_W'(chain[WINDOW_LEN]);
        n_fill       = full_before ? r_fill : r_fill + FILL_W'(1);
        n_window_sum = full_before ? WSUM_W'(n_hist_sum) : r_window_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_hist_sum   <= '0;
            r_window_sum <= '0;
        end else if (i_shift) begin
            r_fill       <= n_fill;
            r_hist_sum   <= n_hist_sum;
            r_window_sum <= n_window_sum;
        end
    end

    // Status as seen by the check of the current tick
    assign o_stat.full = (n_fill == FILL_W'(WINDOW_LEN));
    assign o_stat.sum  = n_window_sum;

endmodule
`default_nettype wire

FILE: src/sensor_rate_window_monitor.sv
// Top level: rate window monitor with holdoff, rate check and alarm pacing
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+--------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_heard
//  result   | o_out_valid  | i_out_stall  | o_alarm o_alarm_level o_rate_count
//           |              |              | o_checking
//  config   | i_cfg_we     | (none)       | i_cfg_index i_cfg_data
//
// One tick is taken per cycle while o_in_stall is low; its result is registered
// in r_out, or in r_skid while r_out is stalled. The window update and the rate
// check run in the same cycle. Synchronous reset clears the history cells and
// loads register defaults. A two-entry output stage absorbs a stall: input
// stalls only once both entries hold results.
`default_nettype none
module sensor_rate_window_monitor (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_heard,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_alarm,
    output logic [1:0]                      o_alarm_level,
    output logic [6:0]                      o_rate_count,
    output logic                            o_checking,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [srwm_pkg::CFG_W-1:0] i_cfg_data
);
    import srwm_pkg::*;

    logic [EXP_W-1:0]  r_expected;
    logic [WAIT_W-1:0] r_startup;
    logic [RPT_W-1:0]  r_limit;
    logic [WAIT_W-1:0] r_holdoff, n_holdoff;
    logic [RPT_W-1:0]  r_repeat,  n_repeat;
    logic              accept;
    t_win_stat         win;
    t_result           res;

    logic              out_take;
    logic              r_out_valid, r_skid_valid;
    t_result           r_out, r_skid;

    logic [CMP_W-1:0]  f_x, e_x;
    logic              above, below, mild_low, is_zero, fire;
    logic [RPT_W-1:0]  rep_mid;

    assign accept = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= EXP_RST;
            r_startup  <= WAIT_RST;
            r_limit    <= RPT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EXPECTED: r_expected <= i_cfg_data[EXP_W-1:0];
                CFG_STARTUP:  r_startup  <= i_cfg_data[WAIT_W-1:0];
                CFG_REPEAT:   r_limit    <= i_cfg_data[RPT_W-1:0];
                default:      ;
            endcase
        end
    end

    srwm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (accept),
        .i_heard (i_heard),
        .o_stat  (win)
    );

    // Scaled rate comparisons
    always_comb begin
        f_x      = CMP_W'(win.sum);
        e_x      = CMP_W'(r_expected);
        above    = (f_x * CMP_W'(10)) > (e_x * CMP_W'(11));
        below    = (f_x * CMP_W'(10)) < (e_x * CMP_W'(9));
        mild_low = (f_x * CMP_W'(100)) > (e_x * CMP_W'(66));
        is_zero  = (win.sum == '0);
        fire     = (r_repeat >= r_limit);
    end

    // Holdoff, classification and repeat pacing
    always_comb begin
        n_holdoff    = r_holdoff;
        rep_mid      = r_repeat;
        n_repeat     = r_repeat;
        res.alarm    = 1'b0;
        res.level    = LVL_INFO;
        res.rate     = win.sum[6:0];
        res.checking = 1'b0;
        if (r_holdoff < r_startup) begin
            n_holdoff = r_holdoff + WAIT_W'(1);
        end else begin
            res.checking = 1'b1;
            if (win.full) begin
                priority if (above) begin
                    if (f_x < (e_x * CMP_W'(2))) begin
                        res.alarm = fire;
                        res.level = LVL_INFO;
                        rep_mid   = '0;
                    end else if (fire) begin
                        res.alarm = 1'b1;
                        res.level = LVL_WARN;
                        rep_mid   = '0;
                    end
                end else if (below) begin
                    if (fire) begin
                        res.alarm = 1'b1;
                        rep_mid   = '0;
                        priority if (mild_low) begin
                            res.level = LVL_INFO;
                        end else if (is_zero) begin
                            res.level = LVL_ERROR;
                        end else begin
                            res.level = LVL_WARN;
                        end
                    end
                end else begin
                    res.alarm = 1'b0;
                end
            end
            n_repeat = (rep_mid == RPT_MAX) ? rep_mid : rep_mid + RPT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff <= '0;
            r_repeat  <= '0;
        end else if (accept) begin
            r_holdoff <= n_holdoff;
            r_repeat  <= n_repeat;
        end
    end

    // Two-entry output stage: hold a result in the skid entry while stalled
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_alarm       = r_out.alarm;
    assign o_alarm_level = r_out.level;
    assign o_rate_count  = r_out.rate;
    assign o_checking    = r_out.checking;

endmodule
`default_nettype wire

FILE: test/srwm_alarm_checker.sv
// Checker: watches the monitor's channels, predicts each tick's result and compares
module srwm_alarm_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic                       i_heard,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic                       i_alarm,
    input  wire logic [1:0]                 i_alarm_level,
    input  wire logic [6:0]                 i_rate_count,
    input  wire logic                       i_checking,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [srwm_pkg::CFG_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import srwm_pkg::*;

    // Shadow copy of the registers
    logic [EXP_W-1:0]  exp_count;
    logic [WAIT_W-1:0] wait_ticks;
    logic [RPT_W-1:0]  rpt_limit;

    // Shadow copy of the window, holdoff and alarm pacing
    logic              hist [WINDOW_LEN];
    int unsigned       wr_pos;
    logic [FILL_W-1:0] fill;
    logic [WSUM_W-1:0] wsum;
    logic [WAIT_W-1:0] holdoff;
    logic [RPT_W-1:0]  rpt;

    t_result tick_results_due [$];
    int      fail_total = 0;
    int      due_total  = 0;

    assign o_fail_count = fail_total;
    assign o_due_count  = due_total;

    // Advance the window, holdoff and pacing by one tick and return its result
    function automatic t_result rate_tick(logic heard_bit);
        t_result     res;
        logic        fire;
        int unsigned f;
        int unsigned e;
        int unsigned ones;
        res = '0;
        hist[wr_pos] = heard_bit;
        wr_pos = (wr_pos + 1 >= WINDOW_LEN) ? 0 : wr_pos + 1;
        if (fill >= WINDOW_LEN) begin
            ones = 0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                ones += hist[i];
            end
            wsum = WSUM_W'(ones);
        end else begin
            fill = fill + 1'b1;
        end
        if (holdoff < wait_ticks) begin
            holdoff = holdoff + 1'b1;
        end else begin
            res.checking = 1'b1;
            f    = wsum;
            e    = exp_count;
            fire = (rpt >= rpt_limit);
            // Compare only once the window holds a full set of ticks
            if (fill >= WINDOW_LEN) begin
                if (10 * f > 11 * e) begin
                    // Fast rate: the lower band always restarts the pacing
                    if (f < 2 * e) begin
                        if (fire) begin
                            res.alarm = 1'b1;
                            res.level = LVL_INFO;
                        end
                        rpt = '0;
                    end else if (fire) begin
                        res.alarm = 1'b1;
                        res.level = LVL_WARN;
                        rpt = '0;
                    end
                end else if (10 * f < 9 * e) begin
                    // Slow rate: severity grows as the count drops
                    if (fire) begin
                        res.alarm = 1'b1;
                        rpt = '0;
                        if (100 * f > 66 * e) begin
                            res.level = LVL_INFO;
                        end else if (f == 0) begin
                            res.level = LVL_ERROR;
                        end else begin
                            res.level = LVL_WARN;
                        end
                    end
                end
            end
            if (rpt != RPT_MAX) begin
                rpt = rpt + 1'b1;
            end
        end
        res.rate = wsum[6:0];
        return res;
    endfunction

    // Compare results, predict accepted ticks and track register writes
    always @(posedge i_clk) begin
        t_result want;
        t_result next_res;
        if (!i_rst_n) begin
            exp_count  = EXP_RST;
            wait_ticks = WAIT_RST;
            rpt_limit  = RPT_RST;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                hist[i] = 1'b0;
            end
            wr_pos  = 0;
            fill    = '0;
            wsum    = '0;
            holdoff = '0;
            rpt     = '0;
            tick_results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (tick_results_due.size() == 0) begin
                    $error("result transfer with no tick waiting");
                    fail_total++;
                end else begin
                    want = tick_results_due[0];
                    tick_results_due.delete(0);
                    if (i_alarm !== want.alarm) begin
                        $error("alarm: expected %0d, got %0d", want.alarm, i_alarm);
                        fail_total++;
                    end
                    if (i_alarm_level !== want.level) begin
                        $error("alarm_level: expected %0d, got %0d", want.level, i_alarm_level);
                        fail_total++;
                    end
                    if (i_rate_count !== want.rate) begin
                        $error("rate_count: expected %0d, got %0d", want.rate, i_rate_count);
                        fail_total++;
                    end
                    if (i_checking !== want.checking) begin
                        $error("checking: expected %0d, got %0d", want.checking, i_checking);
                        fail_total++;
                    end
                end
            end
            // A tick taken at the same edge as a write still sees the old registers
            if (i_in_valid && !i_in_stall) begin
                next_res = rate_tick(i_heard);
                tick_results_due.insert(tick_results_due.size(), next_res);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_EXPECTED: exp_count  = i_cfg_data[EXP_W-1:0];
                    CFG_STARTUP:  wait_ticks = i_cfg_data[WAIT_W-1:0];
                    CFG_REPEAT:   rpt_limit  = i_cfg_data[RPT_W-1:0];
                    default: ;
                endcase
            end
        end
        due_total = tick_results_due.size();
    end

endmodule

FILE: test/sensor_rate_window_monitor_test.sv
// Testbench top: drives ticks and register writes into the monitor and gives the verdict
module sensor_rate_window_monitor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srwm_pkg::*;

    localparam int IDLE_LIMIT = 400;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_heard;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_alarm;
    logic [1:0]       o_alarm_level;
    logic [6:0]       o_rate_count;
    logic             o_checking;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    int fail_count;
    int due_count;
    int idle_cycles = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    sensor_rate_window_monitor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_heard       (i_heard),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_alarm       (o_alarm),
        .o_alarm_level (o_alarm_level),
        .o_rate_count  (o_rate_count),
        .o_checking    (o_checking),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    srwm_alarm_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_heard       (i_heard),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_alarm       (o_alarm),
        .i_alarm_level (o_alarm_level),
        .i_rate_count  (o_rate_count),
        .i_checking    (o_checking),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_due_count   (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycles of idling before the next transfer on one side
    function automatic int draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    // Present one tick and hold it until it is taken
    task automatic send_tick(logic heard_bit);
        int gap;
        gap = draw_wait(tx_steady);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_heard    <= heard_bit;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result side: stall for a drawn number of cycles before each transfer
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = draw_wait(rx_steady);
            if (hold > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (hold - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          sent;
        int          phase;
        int          len;
        int unsigned pct;
        logic [6:0]  exp_val;
        logic [3:0]  lim_val;
        logic [15:0] wait_val;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_heard     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_EXPECTED;
        i_cfg_data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: ticks fall inside the start-up holdoff
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        drain_results();

        // Longest holdoff, then cut it below the ticks already seen
        write_reg(CFG_STARTUP, 16'hFFFF);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_results();
        write_reg(CFG_STARTUP, '0);
        write_reg(CFG_REPEAT, '0);
        write_reg(CFG_EXPECTED, CFG_W'(1));

        // Checking with a partly filled window: pacing counts but nothing compares
        for (int i = 0; i < 18; i++) begin
            send_tick(i[0] ^ i[2]);
        end

        // Random phases: new registers, tick density and idling per phase
        sent  = 0;
        phase = 0;
        while (sent < 1075) begin
            drain_results();
            case (phase)
                0: begin
                    exp_val  = 7'd100;
                    lim_val  = 4'd15;
                    wait_val = '0;
                end
                1: begin
                    exp_val  = '0;
                    lim_val  = '0;
                    wait_val = '0;
                end
                2: begin
                    exp_val  = 7'd1;
                    lim_val  = '0;
                    wait_val = '0;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       exp_val = 7'd1;
                        1:       exp_val = 7'd100;
                        default: exp_val = 7'($urandom_range(1, 100));
                    endcase
                    lim_val  = 4'($urandom_range(0, 15));
                    wait_val = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1400)) : '0;
                end
            endcase
            write_reg(CFG_EXPECTED, CFG_W'(exp_val));
            write_reg(CFG_REPEAT, CFG_W'(lim_val));
            write_reg(CFG_STARTUP, CFG_W'(wait_val));

            case ($urandom_range(0, 5))
                0:       pct = 0;
                1:       pct = 100;
                default: pct = $urandom_range(0, 100);
            endcase
            len       = (phase == 0) ? 100 : $urandom_range(40, 120);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                send_tick($urandom_range(0, 99) < pct);
            end
            sent  += len;
            phase++;
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
